/* rtl/core/hsfd_pkg.sv */
// shared types, constants and functions for the humidity sensor frame decoder
// no dependencies

package hsfd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] temperature_tenths;
    logic        [13:0] humidity_centi;
    logic               crc_error;
  } out_item_t;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // byte positions inside one frame
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // scaling: round(k*raw/65535) = floor((2k*raw + 65535) / 131070)
  localparam int unsigned T_SCALE    = 3500;
  localparam int unsigned H_SCALE    = 20000;
  localparam int unsigned H_SCALE_HI = H_SCALE * 256;
  localparam int unsigned ROUND_BIAS = 65535;
  localparam int unsigned T_OFFSET   = 450;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(n / 131070) for n below 2^31, via m = n/2 and m/65535 by shift-add
  function automatic logic [14:0] div_131070(logic [30:0] n);
    logic [29:0] m;
    logic [30:0] s;
    m = n[30:1];
    s = {1'b0, m} + {17'd0, m[29:16]} + 31'd1;
    return s[30:16];
  endfunction

endpackage

/* rtl/core/humidity_sensor_frame_decoder_top.sv */
// humidity sensor frame decoder, top level
// depends on hsfd_pkg

// Takes one sensor byte per transfer, one transfer per clock when the result side keeps
// up. Bytes run temperature high, low, CRC, humidity high, low, CRC; each CRC-8 (poly 0x31,
// init 0xFF) is checked as it arrives. The sixth byte produces one result transfer,
// registered in the output stage, holding tenths of a degree and hundredths of a percent,
// or zeros with crc_error set. frame_start forces the byte to be the first of a frame.
// The scaling multiplies are spread over the frame (temperature at the low byte and its
// CRC byte, humidity at its high and low bytes), so no byte waits on arithmetic; input is
// held off only while a finished result waits in the output register.

module humidity_sensor_frame_decoder_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsfd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hsfd_pkg::out_item_t  out_data
);

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        err_r, err_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [27:0] tsum_r, tsum_nxt;
  logic [10:0] tq_r, tq_nxt;
  logic [30:0] hprod_r, hprod_nxt;
  logic [30:0] hsum_r, hsum_nxt;
  logic        out_valid_r, out_valid_nxt;
  hsfd_pkg::out_item_t out_r, out_nxt;

  logic        in_fire;
  logic        restart;
  logic [2:0]  cur_pos;
  logic [7:0]  cur_crc;
  logic        cur_err;
  logic [7:0]  crc_upd;
  logic        crc_bad;
  logic        frame_err;
  logic [14:0] tq_full;
  logic [14:0] hq_full;
  logic [15:0] t_raw;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign restart = in_data.frame_start || (pos_r > hsfd_pkg::POS_H_CRC);
  assign cur_pos = restart ? hsfd_pkg::POS_T_HI : pos_r;
  assign cur_crc = restart ? hsfd_pkg::CRC_INIT : crc_r;
  assign cur_err = restart ? 1'b0 : err_r;

  assign crc_upd   = hsfd_pkg::crc8_byte(cur_crc, in_data.data_byte);
  assign crc_bad   = (cur_crc != in_data.data_byte);
  assign frame_err = cur_err || crc_bad;
  assign t_raw     = {high_r, in_data.data_byte};
  assign tq_full   = hsfd_pkg::div_131070({3'd0, tsum_r});
  assign hq_full   = hsfd_pkg::div_131070(hsum_r);

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    err_nxt       = err_r;
    high_nxt      = high_r;
    tsum_nxt      = tsum_r;
    tq_nxt        = tq_r;
    hprod_nxt     = hprod_r;
    hsum_nxt      = hsum_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (in_fire) begin
      pos_nxt = cur_pos + 3'd1;
      crc_nxt = crc_upd;
      err_nxt = cur_err;
      case (cur_pos)
        hsfd_pkg::POS_T_HI: begin
          high_nxt = in_data.data_byte;
        end
        hsfd_pkg::POS_T_LO: begin
          tsum_nxt = 28'(t_raw) * 28'(hsfd_pkg::T_SCALE) + 28'(hsfd_pkg::ROUND_BIAS);
        end
        hsfd_pkg::POS_T_CRC: begin
          err_nxt = frame_err;
          crc_nxt = hsfd_pkg::CRC_INIT;
          tq_nxt  = tq_full[10:0];
        end
        hsfd_pkg::POS_H_HI: begin
          hprod_nxt = 31'(in_data.data_byte) * 31'(hsfd_pkg::H_SCALE_HI)
                      + 31'(hsfd_pkg::ROUND_BIAS);
        end
        hsfd_pkg::POS_H_LO: begin
          hsum_nxt = hprod_r + 31'(in_data.data_byte) * 31'(hsfd_pkg::H_SCALE);
        end
        default: begin
          // humidity checksum byte closes the frame
          pos_nxt       = hsfd_pkg::POS_T_HI;
          crc_nxt       = hsfd_pkg::CRC_INIT;
          err_nxt       = 1'b0;
          out_valid_nxt = 1'b1;
          out_nxt.crc_error = frame_err;
          if (frame_err) begin
            out_nxt.temperature_tenths = '0;
            out_nxt.humidity_centi     = '0;
          end else begin
            out_nxt.temperature_tenths =
              $signed(12'(tq_r) - 12'(hsfd_pkg::T_OFFSET));
            out_nxt.humidity_centi = hq_full[13:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= hsfd_pkg::POS_T_HI;
      crc_r       <= hsfd_pkg::CRC_INIT;
      err_r       <= 1'b0;
      high_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      err_r       <= err_nxt;
      high_r      <= high_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tsum_r  <= tsum_nxt;
    tq_r    <= tq_nxt;
    hprod_r <= hprod_nxt;
    hsum_r  <= hsum_nxt;
    out_r   <= out_nxt;
  end

  // frame position stays inside the six-byte frame
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= hsfd_pkg::POS_H_CRC)
    else $error("byte position out of range");

  // a closing byte always loads a result
  a_close_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (cur_pos == hsfd_pkg::POS_H_CRC) |=> out_valid_r)
    else $error("result not loaded after closing byte");

  // error results carry zero values
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.crc_error |->
      (out_r.temperature_tenths == 12'sd0) && (out_r.humidity_centi == 14'd0))
    else $error("error result with nonzero values");

  // good results stay in the sensor range
  a_val_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.crc_error |->
      (out_r.humidity_centi <= 14'd10000) &&
      (out_r.temperature_tenths >= -12'sd450) &&
      (out_r.temperature_tenths <= 12'sd1300))
    else $error("scaled value out of range");

endmodule
